[design/qte_pkg.sv]
// Shared types, constants and the arctangent table of the quaternion to Euler angles unit.
// No dependencies; every other design file imports this package.
`default_nettype none
package qte_pkg;

    localparam int VW     = 40;   // CORDIC vector width
    localparam int ZW     = 26;   // angle accumulator width, 1/65536 degree
    localparam int SQ_STEPS = 29; // square-root digit steps, two radicand bits each
    localparam int RAD_W  = 58;
    localparam int REM_W  = 34;
    localparam int ROOT_W = 29;

    localparam logic signed [ZW-1:0] DEG90  = 26'sd5898240;
    localparam logic signed [ZW-1:0] DEG180 = 26'sd11796480;
    localparam logic signed [ZW:0]   HALF_LSB = 27'sd256;
    localparam logic signed [17:0]   ANG_LIM_PITCH = 18'sd11520;
    localparam logic signed [29:0]   ONE_Q28 = 30'sd268435456;
    localparam logic [15:0]          DECL_RESET = 16'd1316;

    typedef struct packed {
        logic signed [VW-1:0] x;
        logic signed [VW-1:0] y;
        logic signed [ZW-1:0] z;
        logic                 zero;
    } t_cordic;

    typedef struct packed {
        logic [RAD_W-1:0]   rad;
        logic [REM_W-1:0]   rem;
        logic [ROOT_W-1:0]  root;
        logic signed [33:0] yaw_y;
        logic signed [32:0] yaw_x;
        logic signed [33:0] roll_y;
        logic signed [32:0] roll_x;
        logic signed [29:0] s;
    } t_sqrt;

    // atan(2^-i) in 1/65536 degree, rounded to nearest
    function automatic logic [22:0] atan_entry(input int idx);
        logic [22:0] v;
        unique case (idx)
            0:  v = 23'd2949120;
            1:  v = 23'd1740967;
            2:  v = 23'd919879;
            3:  v = 23'd466945;
            4:  v = 23'd234379;
            5:  v = 23'd117304;
            6:  v = 23'd58666;
            7:  v = 23'd29335;
            8:  v = 23'd14668;
            9:  v = 23'd7334;
            10: v = 23'd3667;
            11: v = 23'd1833;
            12: v = 23'd917;
            13: v = 23'd458;
            14: v = 23'd229;
            15: v = 23'd115;
            16: v = 23'd57;
            17: v = 23'd29;
            18: v = 23'd14;
            19: v = 23'd7;
            20: v = 23'd4;
            21: v = 23'd2;
            22: v = 23'd1;
            default: v = 23'd0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

[design/quaternion_to_euler_angles_unit.sv]
// Top level of the quaternion to Euler angles unit: product stages, square-root
// chain and three CORDIC chains. Depends on qte_pkg, qte_sqrt_cell, qte_cordic_cell.
//
// Usage:
//   Input channel i_valid/o_ready carries one quaternion beat (i_q_w..i_q_z,
//   signed Q1.14). Output channel o_valid/i_ready carries one beat of yaw,
//   pitch and roll in 1/128 degree for every input beat, in order.
//   Write i_cfg_we/i_cfg_wdata to load the declination; take effect on the
//   next beat to leave, so write it only while the unit is empty.
//   The pipeline holds four product/sum stages, 29 square-root cells, one
//   pre-rotation stage, the CORDIC cells and the output register.
//   Throughput is one beat per cycle while not stalled: every cell hands its data on.
//   Reset empties the pipeline and loads the declination with +10.28 degrees.
//   When the receiver stalls with a beat waiting in the output register, the
//   whole chain holds and o_ready drops; it rises again the cycle the waiting
//   beat is taken, so a new beat may enter in that same cycle.
`default_nettype none
module quaternion_to_euler_angles_unit #(
    parameter int CORDIC_STAGES = 16
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_cfg_we,
    input  wire  signed [15:0] i_cfg_wdata,
    input  wire                i_valid,
    output logic               o_ready,
    input  wire  signed [15:0] i_q_w,
    input  wire  signed [15:0] i_q_x,
    input  wire  signed [15:0] i_q_y,
    input  wire  signed [15:0] i_q_z,
    output logic               o_valid,
    input  wire                i_ready,
    output logic signed [16:0] o_yaw,
    output logic signed [14:0] o_pitch,
    output logic signed [15:0] o_roll
);
    import qte_pkg::*;

    localparam int DEPTH = 35 + CORDIC_STAGES;

    logic             en;
    logic [DEPTH-1:0] r_vld;
    logic [15:0]      r_decl;

    logic signed [15:0] r_w, r_x, r_y, r_z;
    logic signed [31:0] r_ww, r_xx, r_yy, r_zz, r_xy, r_wz, r_xz, r_wy, r_wx, r_yz;
    logic signed [33:0] r_yaw_y, r_roll_y;
    logic signed [32:0] r_yaw_x, r_roll_x;
    logic signed [29:0] r_s;
    logic signed [33:0] s_raw;
    logic signed [29:0] s_clamp;
    logic signed [59:0] r_ss;
    logic signed [33:0] r_yaw_y2, r_roll_y2;
    logic signed [32:0] r_yaw_x2, r_roll_x2;
    logic signed [29:0] r_s2;

    t_sqrt   sq_chain [0:SQ_STEPS];
    t_cordic yc [0:CORDIC_STAGES];
    t_cordic pc [0:CORDIC_STAGES];
    t_cordic rc [0:CORDIC_STAGES];
    t_cordic r_pre_y, r_pre_p, r_pre_r;

    logic signed [15:0] a_yaw, a_pitch, a_roll;
    logic signed [16:0] yaw_full;
    logic signed [15:0] pitch_cl;

    // Advance the whole chain whenever the output slot is free or being taken
    assign en      = !o_valid || i_ready;
    assign o_ready = en;
    assign o_valid = r_vld[DEPTH-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_decl <= DECL_RESET;
        end else begin
            if (en) begin
                r_vld <= {r_vld[DEPTH-2:0], i_valid};
            end
            if (i_cfg_we) begin
                r_decl <= i_cfg_wdata;
            end
        end
    end

    // Clamp the asin argument to +-1.0 in Q28
    always_comb begin
        s_raw = 34'sd2 * ($signed({r_xz[31], r_xz}) - $signed({r_wy[31], r_wy}));
        if (s_raw > 34'sd268435456) begin
            s_clamp = ONE_Q28;
        end else if (s_raw < -34'sd268435456) begin
            s_clamp = -ONE_Q28;
        end else begin
            s_clamp = s_raw[29:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_w <= i_q_w;
            r_x <= i_q_x;
            r_y <= i_q_y;
            r_z <= i_q_z;

            r_ww <= r_w * r_w;
            r_xx <= r_x * r_x;
            r_yy <= r_y * r_y;
            r_zz <= r_z * r_z;
            r_xy <= r_x * r_y;
            r_wz <= r_w * r_z;
            r_xz <= r_x * r_z;
            r_wy <= r_w * r_y;
            r_wx <= r_w * r_x;
            r_yz <= r_y * r_z;

            r_yaw_y  <= 34'sd2 * ($signed({r_xy[31], r_xy}) + $signed({r_wz[31], r_wz}));
            r_yaw_x  <= 33'(r_ww) + 33'(r_xx) - 33'(r_yy) - 33'(r_zz);
            r_roll_y <= 34'sd2 * ($signed({r_wx[31], r_wx}) + $signed({r_yz[31], r_yz}));
            r_roll_x <= 33'(r_ww) - 33'(r_xx) - 33'(r_yy) + 33'(r_zz);
            r_s      <= s_clamp;

            r_ss      <= r_s * r_s;
            r_yaw_y2  <= r_yaw_y;
            r_yaw_x2  <= r_yaw_x;
            r_roll_y2 <= r_roll_y;
            r_roll_x2 <= r_roll_x;
            r_s2      <= r_s;
        end
    end

    // Feed the square-root chain with 1.0^2 - s^2 and carry the other operands
    always_comb begin
        sq_chain[0].rad    = 58'd72057594037927936 - r_ss[RAD_W-1:0];
        sq_chain[0].rem    = '0;
        sq_chain[0].root   = '0;
        sq_chain[0].yaw_y  = r_yaw_y2;
        sq_chain[0].yaw_x  = r_yaw_x2;
        sq_chain[0].roll_y = r_roll_y2;
        sq_chain[0].roll_x = r_roll_x2;
        sq_chain[0].s      = r_s2;
    end

    for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
        qte_sqrt_cell u_cell (
            .i_clk (i_clk),
            .i_en  (en),
            .i_d   (sq_chain[k]),
            .o_d   (sq_chain[k+1])
        );
    end

    // Fold a left-half vector into the right half by a quarter turn
    function automatic t_cordic prerot(input logic signed [VW-1:0] x,
                                       input logic signed [VW-1:0] y);
        t_cordic c;
        c.zero = (x == '0) && (y == '0);
        c.x    = x;
        c.y    = y;
        c.z    = '0;
        if (x[VW-1]) begin
            if (!y[VW-1]) begin
                c.x = y;
                c.y = -x;
                c.z = DEG90;
            end else begin
                c.x = -y;
                c.y = x;
                c.z = -DEG90;
            end
        end
        return c;
    endfunction

    // Clamp to +-180 degrees and round to 1/128 degree, half up
    function automatic logic signed [15:0] finish(input t_cordic c);
        logic signed [ZW-1:0] zc;
        logic signed [ZW:0]   t;
        logic signed [ZW:0]   r;
        zc = c.z;
        if (c.z > DEG180) begin
            zc = DEG180;
        end else if (c.z < -DEG180) begin
            zc = -DEG180;
        end
        t = $signed({zc[ZW-1], zc}) + HALF_LSB;
        r = t >>> 9;
        return c.zero ? 16'sd0 : r[15:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pre_y <= prerot(VW'(sq_chain[SQ_STEPS].yaw_x), VW'(sq_chain[SQ_STEPS].yaw_y));
            r_pre_p <= prerot($signed({{(VW-ROOT_W){1'b0}}, sq_chain[SQ_STEPS].root}),
                              VW'(sq_chain[SQ_STEPS].s));
            r_pre_r <= prerot(VW'(sq_chain[SQ_STEPS].roll_x),
                              VW'(sq_chain[SQ_STEPS].roll_y));
        end
    end

    assign yc[0] = r_pre_y;
    assign pc[0] = r_pre_p;
    assign rc[0] = r_pre_r;

    for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cordic
        qte_cordic_cell #(.STAGE(k)) u_yaw (
            .i_clk (i_clk), .i_en (en), .i_d (yc[k]), .o_d (yc[k+1])
        );
        qte_cordic_cell #(.STAGE(k)) u_pitch (
            .i_clk (i_clk), .i_en (en), .i_d (pc[k]), .o_d (pc[k+1])
        );
        qte_cordic_cell #(.STAGE(k)) u_roll (
            .i_clk (i_clk), .i_en (en), .i_d (rc[k]), .o_d (rc[k+1])
        );
    end

    always_comb begin
        a_yaw   = finish(yc[CORDIC_STAGES]);
        a_pitch = finish(pc[CORDIC_STAGES]);
        a_roll  = finish(rc[CORDIC_STAGES]);
        yaw_full = $signed({a_yaw[15], a_yaw}) - $signed({r_decl[15], r_decl});
        if ($signed({{2{a_pitch[15]}}, a_pitch}) > ANG_LIM_PITCH) begin
            pitch_cl = 16'sd11520;
        end else if ($signed({{2{a_pitch[15]}}, a_pitch}) < -ANG_LIM_PITCH) begin
            pitch_cl = -16'sd11520;
        end else begin
            pitch_cl = a_pitch;
        end
    end

    // Hold the result beat until the receiver takes it
    always_ff @(posedge i_clk) begin
        if (en) begin
            o_yaw   <= yaw_full;
            o_pitch <= pitch_cl[14:0];
            o_roll  <= -a_roll;
        end
    end
endmodule
`default_nettype wire

[design/qte_sqrt_cell.sv]
// One registered digit step of the integer square root chain; carries the other
// angle operands alongside. Depends on qte_pkg.
`default_nettype none
module qte_sqrt_cell (
    input  wire             i_clk,
    input  wire             i_en,
    input  qte_pkg::t_sqrt  i_d,
    output qte_pkg::t_sqrt  o_d
);
    import qte_pkg::*;

    t_sqrt            r_d;
    t_sqrt            n_d;
    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;

    always_comb begin
        n_d    = i_d;
        rem_sh = {i_d.rem[REM_W-3:0], i_d.rad[RAD_W-1 -: 2]};
        trial  = {{(REM_W-ROOT_W-2){1'b0}}, i_d.root, 2'b01};
        n_d.rad = {i_d.rad[RAD_W-3:0], 2'b00};
        if (rem_sh >= trial) begin
            n_d.rem  = rem_sh - trial;
            n_d.root = {i_d.root[ROOT_W-2:0], 1'b1};
        end else begin
            n_d.rem  = rem_sh;
            n_d.root = {i_d.root[ROOT_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_d = r_d;
endmodule
`default_nettype wire

[design/qte_cordic_cell.sv]
// One registered vectoring CORDIC rotation with a fixed shift.
// Depends on qte_pkg for the vector type and the arctangent table.
`default_nettype none
module qte_cordic_cell #(
    parameter int STAGE = 0
) (
    input  wire              i_clk,
    input  wire              i_en,
    input  qte_pkg::t_cordic i_d,
    output qte_pkg::t_cordic o_d
);
    import qte_pkg::*;

    t_cordic              r_d;
    t_cordic              n_d;
    logic signed [VW-1:0] dx;
    logic signed [VW-1:0] dy;
    logic signed [ZW-1:0] da;

    always_comb begin
        n_d = i_d;
        dx  = i_d.y >>> STAGE;
        dy  = i_d.x >>> STAGE;
        da  = $signed({{(ZW-23){1'b0}}, atan_entry(STAGE)});
        if (!i_d.y[VW-1]) begin
            n_d.x = i_d.x + dx;
            n_d.y = i_d.y - dy;
            n_d.z = i_d.z + da;
        end else begin
            n_d.x = i_d.x - dx;
            n_d.y = i_d.y + dy;
            n_d.z = i_d.z - da;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_d = r_d;
endmodule
`default_nettype wire

[verif/tb.sv]
// Self-checking testbench for quaternion_to_euler_angles_unit.
// A directed table and random quaternions, with random idling on both sides, are checked
// against a built-in CORDIC angle predictor. Depends only on the design files.
`timescale 1ns / 1ps
module tb;

    localparam int        STAGES      = 16;
    localparam int        LATENCY     = 35 + STAGES;
    localparam longint    DEG90_FINE  = 64'sd5898240;
    localparam longint    DEG180_FINE = 64'sd11796480;
    localparam longint    ONE_Q28     = 64'sd268435456;
    localparam longint    ANG_LIM     = 64'sd23040;
    localparam longint    PITCH_LIM   = 64'sd11520;
    localparam bit [15:0] DECL_AT_RESET = 16'd1316;
    localparam int        N_RANDOM    = 150;   // per declination phase, half in the last

    typedef struct {
        logic signed [16:0] yaw;
        logic signed [14:0] pitch;
        logic signed [15:0] roll;
    } t_angles;

    typedef struct {
        logic signed [15:0] w, x, y, z;
        bit                 typed;   // yaw and roll given by hand
        logic signed [16:0] yaw;
        logic signed [15:0] roll;
    } t_row;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic signed [15:0] i_cfg_wdata = '0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic signed [15:0] i_q_w = '0, i_q_x = '0, i_q_y = '0, i_q_z = '0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic signed [16:0] o_yaw;
    logic signed [14:0] o_pitch;
    logic signed [15:0] o_roll;

    t_angles     pending_angles[$];
    logic [15:0] decl_model;
    int          n_errors = 0;
    bit          long_hold_req = 1'b0;

    quaternion_to_euler_angles_unit #(.CORDIC_STAGES(STAGES)) uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_q_w(i_q_w), .i_q_x(i_q_x), .i_q_y(i_q_y), .i_q_z(i_q_z),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_yaw(o_yaw), .o_pitch(o_pitch), .o_roll(o_roll)
    );

    always #5 i_clk = ~i_clk;

    // atan(2^-i) in 1/65536 degree, rounded to nearest
    function automatic longint atan_step(input int i);
        longint tbl[24] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
                            29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115,
                            57, 29, 14, 7, 4, 2, 1, 0};
        return tbl[i];
    endfunction

    // vectoring CORDIC, result in 1/128 degree
    function automatic longint cordic_atan2(input longint yy, input longint xx);
        longint ax, ay, az, dx, dy, t, r;
        ax = xx;
        ay = yy;
        az = 0;
        if (ax == 0 && ay == 0) return 0;
        // pre-rotate the left half-plane by a quarter turn
        if (ax < 0) begin
            t = ax;
            if (ay >= 0) begin
                ax = ay;  ay = -t; az = DEG90_FINE;
            end else begin
                ax = -ay; ay = t;  az = -DEG90_FINE;
            end
        end
        for (int i = 0; i < STAGES && i < 24; i++) begin
            dx = ay >>> i;
            dy = ax >>> i;
            if (ay >= 0) begin
                ax += dx; ay -= dy; az += atan_step(i);
            end else begin
                ax -= dx; ay += dy; az -= atan_step(i);
            end
        end
        if (az > DEG180_FINE) az = DEG180_FINE;
        if (az < -DEG180_FINE) az = -DEG180_FINE;
        r = (az + 256) >>> 9;
        if (r > ANG_LIM) r = ANG_LIM;
        if (r < -ANG_LIM) r = -ANG_LIM;
        return r;
    endfunction

    function automatic longint unsigned floor_sqrt(input longint unsigned v);
        longint unsigned rem, root, b;
        rem = v;
        root = 0;
        b = 64'd1 << 62;
        while (b > rem) b >>= 2;
        while (b != 0) begin
            if (rem >= root + b) begin
                rem -= root + b;
                root = (root >> 1) + b;
            end else begin
                root >>= 1;
            end
            b >>= 2;
        end
        return root;
    endfunction

    function automatic t_angles euler_from_quat(input logic signed [15:0] qw, qx, qy, qz,
                                                input logic [15:0] decl);
        longint  w, x, y, z, s, c, yaw, pitch, roll;
        t_angles a;
        w = qw; x = qx; y = qy; z = qz;
        yaw = cordic_atan2(2 * (x * y + w * z), w * w + x * x - y * y - z * z);
        yaw -= longint'($signed(decl));
        // clamp the sine so that asin stays defined
        s = 2 * (x * z - w * y);
        if (s > ONE_Q28) s = ONE_Q28;
        if (s < -ONE_Q28) s = -ONE_Q28;
        c = longint'(floor_sqrt((64'd1 << 56) - longint'(s * s)));
        pitch = cordic_atan2(s, c);
        if (pitch > PITCH_LIM) pitch = PITCH_LIM;
        if (pitch < -PITCH_LIM) pitch = -PITCH_LIM;
        roll = -cordic_atan2(2 * (w * x + y * z), w * w - x * x - y * y + z * z);
        a.yaw = yaw[16:0];
        a.pitch = pitch[14:0];
        a.roll = roll[15:0];
        return a;
    endfunction

    // Offer one quaternion beat and hold it until accepted; queue its expected angles.
    task automatic send_quat(input logic signed [15:0] w, x, y, z,
                             input bit typed = 0, input logic signed [16:0] tyaw = '0,
                             input logic signed [15:0] troll = '0);
        int      gap;
        t_angles a;
        gap = $urandom_range(0, 3);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_q_w <= w; i_q_x <= x; i_q_y <= y; i_q_z <= z;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        a = euler_from_quat(w, x, y, z, decl_model);
        if (typed) begin
            a.yaw = tyaw;
            a.roll = troll;
        end
        pending_angles.push_back(a);
    endtask

    // Drain the pipeline, then load a new declination.
    task automatic load_declination(input logic [15:0] v);
        i_valid <= 1'b0;
        wait (pending_angles.size() == 0);
        repeat (LATENCY + 4) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        decl_model = v;
    endtask

    function automatic logic signed [15:0] rand_comp(input int mode);
        logic signed [15:0] picks[5] = '{16'sd0, 16'sd16384, -16'sd16384, 16'sd32767,
                                         -16'sd32768};
        if (mode < 70) return 16'($signed($urandom_range(0, 32768)) - 16384);
        if (mode < 85) return 16'($urandom);
        return picks[$urandom_range(0, 4)];
    endfunction

    task automatic send_random(input int n);
        int mode;
        for (int k = 0; k < n; k++) begin
            mode = $urandom_range(0, 99);
            send_quat(rand_comp(mode), rand_comp(mode), rand_comp(mode), rand_comp(mode));
        end
    endtask

    // Receiver: random stall per beat, one long hold-off on request, check every beat.
    initial begin : sink
        int      stall;
        t_angles e;
        @(posedge i_rst_n);
        forever begin
            stall = $urandom_range(0, 3);
            if (long_hold_req) begin
                stall = 300;
                long_hold_req = 1'b0;
            end
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
            if (pending_angles.size() == 0) begin
                $display("%0t: unexpected beat yaw=%0d pitch=%0d roll=%0d",
                         $time, o_yaw, o_pitch, o_roll);
                n_errors++;
            end else begin
                e = pending_angles.pop_front();
                if (o_yaw !== e.yaw) begin
                    $display("%0t: yaw expected %0d actual %0d", $time, e.yaw, o_yaw);
                    n_errors++;
                end
                if (o_pitch !== e.pitch) begin
                    $display("%0t: pitch expected %0d actual %0d", $time, e.pitch, o_pitch);
                    n_errors++;
                end
                if (o_roll !== e.roll) begin
                    $display("%0t: roll expected %0d actual %0d", $time, e.roll, o_roll);
                    n_errors++;
                end
            end
        end
    end

    initial begin : stimulus
        t_row rows[] = '{
            // all-zero quaternion: yaw and roll atan2 operands all zero
            '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1, -17'sd1316, 16'sd0},
            '{16'sd16384, 16'sd0, 16'sd0, 16'sd0, 1'b0, '0, '0},
            '{-16'sd16384, 16'sd0, 16'sd0, 16'sd0, 1'b0, '0, '0},
            '{16'sd0, 16'sd16384, 16'sd0, 16'sd0, 1'b0, '0, '0},
            '{16'sd0, 16'sd0, 16'sd16384, 16'sd0, 1'b0, '0, '0},
            '{16'sd0, 16'sd0, 16'sd0, 16'sd16384, 1'b0, '0, '0},
            '{16'sd0, -16'sd16384, 16'sd0, -16'sd16384, 1'b0, '0, '0},
            // sine exactly -1 and +1
            '{16'sd8192, -16'sd8192, 16'sd8192, 16'sd8192, 1'b0, '0, '0},
            '{16'sd8192, 16'sd8192, -16'sd8192, 16'sd8192, 1'b0, '0, '0},
            // sine beyond +-1
            '{16'sd16384, 16'sd0, 16'sd16384, 16'sd0, 1'b0, '0, '0},
            '{16'sd0, 16'sd16384, 16'sd0, 16'sd16384, 1'b0, '0, '0},
            // left half-plane, y operand either sign
            '{16'sd100, 16'sd0, 16'sd16384, 16'sd100, 1'b0, '0, '0},
            '{16'sd100, 16'sd0, 16'sd16384, -16'sd100, 1'b0, '0, '0},
            '{16'sd100, 16'sd16384, 16'sd0, 16'sd0, 1'b0, '0, '0},
            '{-16'sd100, 16'sd16384, 16'sd0, 16'sd0, 1'b0, '0, '0},
            '{16'sd0, 16'sd16384, 16'sd0, 16'sd0, 1'b0, '0, '0},
            // out-of-range components, then two 90-degree rotations
            '{16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, 1'b0, '0, '0},
            '{-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768, 1'b0, '0, '0},
            '{16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768, 1'b0, '0, '0},
            '{-16'sd32768, 16'sd0, 16'sd32767, 16'sd1, 1'b0, '0, '0},
            '{16'sd11585, 16'sd11585, 16'sd0, 16'sd0, 1'b0, '0, '0},
            '{16'sd11585, 16'sd0, 16'sd0, -16'sd11585, 1'b0, '0, '0}
        };
        logic [15:0] decl_set[5] = '{-16'sd23040, 16'sd23040, 16'sd0, 16'sd7, -16'sd1};
        decl_model = DECL_AT_RESET;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (rows[r])
            send_quat(rows[r].w, rows[r].x, rows[r].y, rows[r].z,
                      rows[r].typed, rows[r].yaw, rows[r].roll);
        // fill the pipeline against a stalled receiver
        long_hold_req = 1'b1;
        send_random(N_RANDOM);
        foreach (decl_set[d]) begin
            load_declination(decl_set[d]);
            send_random(N_RANDOM);
        end
        load_declination(16'($signed($urandom_range(0, 46080)) - 23040));
        send_random(N_RANDOM / 2);
        i_valid <= 1'b0;
        wait (pending_angles.size() == 0);
        repeat (LATENCY + 4) @(posedge i_clk);
        if (n_errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin : watchdog
        #20ms;
        $display("%0t: timeout with %0d beats outstanding", $time, pending_angles.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
